// File: sv/ipv4_receive_header_checker_core_assert.svh
// assertion macros for the ipv4 receive header checker rtl
// depends on nothing; included by modules that carry concurrent checks
`ifndef IPV4_RECEIVE_HEADER_CHECKER_CORE_ASSERT_SVH
`define IPV4_RECEIVE_HEADER_CHECKER_CORE_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define IHC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ihc check failed");

// implication checked at every clock edge out of reset
`define IHC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ihc check failed");

`endif

// File: sv/ihc_pkg.sv
// types and constants for the ipv4 receive header checker
// no dependencies; imported by every module of the block
`default_nettype none

package ihc_pkg;

  // verdict codes, first failing check wins
  typedef enum logic [2:0] {
    VERDICT_ACCEPT    = 3'd0,
    VERDICT_SHORT     = 3'd1,
    VERDICT_TTL_ZERO  = 3'd2,
    VERDICT_BAD_VER   = 3'd3,
    VERDICT_BAD_LEN   = 3'd4,
    VERDICT_BAD_CSUM  = 3'd5,
    VERDICT_FRAGMENT  = 3'd6
  } verdict_e;

  // header byte offsets
  localparam logic [15:0] OFS_VER_IHL = 16'd0;
  localparam logic [15:0] OFS_TLEN_HI = 16'd2;
  localparam logic [15:0] OFS_TLEN_LO = 16'd3;
  localparam logic [15:0] OFS_FRAG_HI = 16'd6;
  localparam logic [15:0] OFS_FRAG_LO = 16'd7;
  localparam logic [15:0] OFS_TTL     = 16'd8;
  localparam logic [15:0] OFS_PROTO   = 16'd9;
  localparam logic [15:0] OFS_SRC0    = 16'd12;
  localparam logic [15:0] OFS_SRC1    = 16'd13;
  localparam logic [15:0] OFS_SRC2    = 16'd14;
  localparam logic [15:0] OFS_SRC3    = 16'd15;
  localparam logic [15:0] OFS_DST0    = 16'd16;
  localparam logic [15:0] OFS_DST1    = 16'd17;
  localparam logic [15:0] OFS_DST2    = 16'd18;
  localparam logic [15:0] OFS_DST3    = 16'd19;

  localparam logic [15:0] MIN_PKT_LEN  = 16'd20;
  localparam logic [3:0]  IPV4_VERSION = 4'd4;
  localparam logic [7:0]  PROTO_ICMP   = 8'd1;
  localparam logic [15:0] MF_BIT       = 16'h2000;
  localparam logic [15:0] OFFSET_MASK  = 16'h1fff;
  localparam logic [15:0] CSUM_GOOD    = 16'hffff;

  localparam int unsigned ACC_W     = 22;
  localparam int unsigned OUT_BITS  = 98;
  localparam int unsigned OUT_W     = 104;

  // per-packet summary handed from the front to the verdict stage
  typedef struct packed {
    logic [15:0]      byte_count;
    logic [7:0]       version_ihl;
    logic [7:0]       ttl;
    logic [15:0]      total_length;
    logic [15:0]      fragment_word;
    logic [7:0]       protocol;
    logic [31:0]      src_addr;
    logic [31:0]      dst_addr;
    logic [ACC_W-1:0] csum_acc;
  } pkt_rec_t;

endpackage

`default_nettype wire

// File: sv/ihc_front.sv
// front part: per-byte header capture and running checksum
// depends on ihc_pkg; emits one summary record per packet
`default_nettype none

module ihc_front import ihc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     beat_i,       // input beat accepted this cycle
  input  wire logic [7:0] data_byte_i,
  input  wire logic     last_byte_i,
  output logic          push_o,
  output pkt_rec_t      rec_o
);

  logic [15:0]      count_q, count_d;
  logic [7:0]       vihl_q, vihl_d;
  logic [7:0]       ttl_q, ttl_d;
  logic [15:0]      tlen_q, tlen_d;
  logic [15:0]      frag_q, frag_d;
  logic [7:0]       proto_q, proto_d;
  logic [31:0]      src_q, src_d;
  logic [31:0]      dst_q, dst_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [7:0]       hold_q, hold_d;
  logic [5:0]       hlen;

  // field capture by byte offset
  always_comb begin
    count_d = (count_q == 16'hffff) ? count_q : count_q + 16'd1;
    vihl_d  = vihl_q;
    ttl_d   = ttl_q;
    tlen_d  = tlen_q;
    frag_d  = frag_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    case (count_q)
      OFS_VER_IHL: vihl_d = data_byte_i;
      OFS_TLEN_HI: tlen_d = {data_byte_i, tlen_q[7:0]};
      OFS_TLEN_LO: tlen_d = {tlen_q[15:8], data_byte_i};
      OFS_FRAG_HI: frag_d = {data_byte_i, frag_q[7:0]};
      OFS_FRAG_LO: frag_d = {frag_q[15:8], data_byte_i};
      OFS_TTL:     ttl_d = data_byte_i;
      OFS_PROTO:   proto_d = data_byte_i;
      OFS_SRC0, OFS_SRC1, OFS_SRC2, OFS_SRC3: begin
        src_d = {src_q[23:0], data_byte_i};
      end
      OFS_DST0, OFS_DST1, OFS_DST2, OFS_DST3: begin
        dst_d = {dst_q[23:0], data_byte_i};
      end
      default: ;
    endcase
  end

  // checksum over the header words, high byte held until its partner arrives
  assign hlen = {vihl_d[3:0], 2'b00};

  always_comb begin
    acc_d  = acc_q;
    hold_d = hold_q;
    if (count_q < {10'd0, hlen}) begin
      if (!count_q[0]) begin
        hold_d = data_byte_i;
      end else begin
        acc_d = acc_q + {6'd0, hold_q, data_byte_i};
      end
    end
  end

  // summary record of the packet as of its last byte
  always_comb begin
    rec_o.byte_count    = count_d;
    rec_o.version_ihl   = vihl_d;
    rec_o.ttl           = ttl_d;
    rec_o.total_length  = tlen_d;
    rec_o.fragment_word = frag_d;
    rec_o.protocol      = proto_d;
    rec_o.src_addr      = src_d;
    rec_o.dst_addr      = dst_d;
    rec_o.csum_acc      = acc_d;
  end

  assign push_o = beat_i & last_byte_i;

  // state update, cleared after the last byte of each packet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      vihl_q  <= '0;
      ttl_q   <= '0;
      tlen_q  <= '0;
      frag_q  <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      acc_q   <= '0;
      hold_q  <= '0;
    end else if (beat_i) begin
      if (last_byte_i) begin
        count_q <= '0;
        vihl_q  <= '0;
        ttl_q   <= '0;
        tlen_q  <= '0;
        frag_q  <= '0;
        proto_q <= '0;
        src_q   <= '0;
        dst_q   <= '0;
        acc_q   <= '0;
        hold_q  <= '0;
      end else begin
        count_q <= count_d;
        vihl_q  <= vihl_d;
        ttl_q   <= ttl_d;
        tlen_q  <= tlen_d;
        frag_q  <= frag_d;
        proto_q <= proto_d;
        src_q   <= src_d;
        dst_q   <= dst_d;
        acc_q   <= acc_d;
        hold_q  <= hold_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/ihc_queue.sv
// two-entry queue of packet summaries between front and verdict stage
// depends on ihc_pkg and the assertion macro header
`default_nettype none

`include "ipv4_receive_header_checker_core_assert.svh"

module ihc_queue import ihc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire pkt_rec_t push_rec_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output pkt_rec_t      head_o
);

  pkt_rec_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  `IHC_ASSERT(a_level_bound, clk_i, rst_ni, count_q != 2'd3)
  `IHC_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, full_o && !pop_i, !push_i)
  `IHC_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, !valid_o, !pop_i)
  `IHC_ASSERT_IMPL(a_ptr_gap, clk_i, rst_ni, count_q == 2'd1, wr_ptr_q != rd_ptr_q)

endmodule

`default_nettype wire

// File: sv/ihc_back.sv
// back part: verdict, payload length and output beat register
// depends on ihc_pkg; takes summaries from ihc_queue
`default_nettype none

module ihc_back import ihc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rec_valid_i,
  input  wire pkt_rec_t         rec_i,
  output logic                  pop_o,
  output logic                  m_valid_o,
  input  wire logic             m_ready_i,
  output logic [OUT_W-1:0]      m_data_o
);

  logic [5:0]       hlen;
  logic [16:0]      fold1, fold2;
  logic [15:0]      plen;
  logic             icmp;
  verdict_e         verdict;
  logic             valid_q;
  logic [OUT_W-1:0] data_q;

  // end-around carry fold of the checksum accumulator
  assign hlen  = {rec_i.version_ihl[3:0], 2'b00};
  assign fold1 = {1'b0, rec_i.csum_acc[15:0]} + {11'd0, rec_i.csum_acc[ACC_W-1:16]};
  assign fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};

  // checks in priority order
  always_comb begin
    if (rec_i.byte_count < MIN_PKT_LEN) begin
      verdict = VERDICT_SHORT;
    end else if (rec_i.ttl == 8'd0) begin
      verdict = VERDICT_TTL_ZERO;
    end else if (rec_i.version_ihl[7:4] != IPV4_VERSION) begin
      verdict = VERDICT_BAD_VER;
    end else if (rec_i.byte_count < {10'd0, hlen} ||
                 rec_i.byte_count < rec_i.total_length) begin
      verdict = VERDICT_BAD_LEN;
    end else if (fold2[15:0] != CSUM_GOOD) begin
      verdict = VERDICT_BAD_CSUM;
    end else if ((rec_i.fragment_word & (MF_BIT | OFFSET_MASK)) != 16'd0) begin
      verdict = VERDICT_FRAGMENT;
    end else begin
      verdict = VERDICT_ACCEPT;
    end
  end

  // payload length clamps at zero
  assign plen = (rec_i.total_length > {10'd0, hlen}) ?
                rec_i.total_length - {10'd0, hlen} : 16'd0;
  assign icmp = (verdict == VERDICT_ACCEPT) && (rec_i.protocol == PROTO_ICMP);

  assign pop_o = rec_valid_i && (!valid_q || m_ready_i);

  // output register, refilled whenever it drains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= {{(OUT_W - OUT_BITS){1'b0}}, rec_i.dst_addr, rec_i.src_addr, plen,
                 hlen, rec_i.protocol, icmp, verdict};
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;

endmodule

`default_nettype wire

// File: sv/ipv4_receive_header_checker_core.sv
// top level of the ipv4 receive header checker
// depends on ihc_pkg, ihc_front, ihc_queue and ihc_back
`default_nettype none

// Takes one packet byte per beat (tlast on the final byte) and gives one
// verdict beat per packet. Bytes are taken every cycle while the queue is not
// full: the front captures header fields and sums the checksum words as each
// byte arrives, and hands a summary to a two-entry queue on the last byte.
// The verdict stage drains that queue into an output register, so each verdict
// passes the queue and then the output register after the last byte. The input
// stalls only while the queue is full, that is, with two verdicts pending
// behind a stalled output. Verdict codes: 0 accepted, 1 short, 2 ttl zero,
// 3 bad version, 4 bad length, 5 bad checksum, 6 fragmented.
module ipv4_receive_header_checker_core import ihc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic         s_axis_tlast_i,   // last_byte
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // [2:0] verdict, [3] deliver_icmp, [11:4] protocol_number,
  // [17:12] header_length, [33:18] payload_length,
  // [65:34] source_address, [97:66] destination_address, rest zero
  output logic [OUT_W-1:0]  m_axis_tdata_o
);

  logic     beat;
  logic     push, full, pop, head_valid;
  pkt_rec_t push_rec, head_rec;

  assign s_axis_tready_o = !full;
  assign beat            = s_axis_tvalid_i && s_axis_tready_o;

  // byte capture and checksum
  ihc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .data_byte_i (s_axis_tdata_i),
    .last_byte_i (s_axis_tlast_i),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  // summary queue
  ihc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (head_valid),
    .head_o     (head_rec)
  );

  // verdict and output beat
  ihc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (head_valid),
    .rec_i       (head_rec),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_data_o    (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

// File: tb/ipv4_receive_header_checker_core_tb.sv
// self-checking testbench for ipv4_receive_header_checker_core
// depends on ihc_pkg and the core rtl; byte-stream driver, verdict monitor,
// and a cycle-free predictor of the header checks

module ipv4_receive_header_checker_core_tb;
  import ihc_pkg::*;

  localparam int unsigned HOLD_CYCLES = 300;

  // one input beat: packet byte plus end-of-packet mark
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_beat_t;

  // verdict beat, lowest field last so it overlays m_axis_tdata
  typedef struct packed {
    logic [OUT_W-OUT_BITS-1:0] pad;
    logic [31:0]               dst;
    logic [31:0]               src;
    logic [15:0]               plen;
    logic [5:0]                hlen;
    logic [7:0]                proto;
    logic                      icmp;
    verdict_e                  verdict;
  } verdict_beat_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_tvalid;
  logic             s_tready;
  logic [7:0]       s_tdata;    // [7:0] data_byte
  logic             s_tlast;    // last_byte
  logic             m_tvalid;
  logic             m_tready;
  // [2:0] verdict, [3] deliver_icmp, [11:4] protocol_number,
  // [17:12] header_length, [33:18] payload_length,
  // [65:34] source_address, [97:66] destination_address
  logic [OUT_W-1:0] m_tdata;

  byte_beat_t    rx_byte_q [$];
  verdict_beat_t verdict_q [$];
  byte_beat_t    next_beat;
  verdict_beat_t got_beat;
  verdict_beat_t want_beat;
  int            errors = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   hold_seq = 0;
  int unsigned   hold_seen;
  int unsigned   hold_left;
  int            sent;

  // predictor state
  logic [15:0]      seen_bytes = '0;
  logic [7:0]       ver_ihl_r = '0;
  logic [7:0]       ttl_r = '0;
  logic [15:0]      tot_len_r = '0;
  logic [15:0]      frag_r = '0;
  logic [7:0]       proto_r = '0;
  logic [31:0]      src_r = '0;
  logic [31:0]      dst_r = '0;
  logic [ACC_W-1:0] csum_acc_r = '0;
  logic [7:0]       hi_byte_r = '0;

  ipv4_receive_header_checker_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // capture header fields and sum, verdict on the final byte
  task automatic header_check_step(input logic [7:0] b, input logic last);
    logic [15:0]   idx;
    logic [5:0]    hlen;
    logic [16:0]   fold;
    verdict_beat_t res;
    idx = seen_bytes;
    if (seen_bytes != 16'hffff) seen_bytes = seen_bytes + 16'd1;
    case (idx)
      OFS_VER_IHL: ver_ihl_r = b;
      OFS_TLEN_HI: tot_len_r[15:8] = b;
      OFS_TLEN_LO: tot_len_r[7:0] = b;
      OFS_FRAG_HI: frag_r[15:8] = b;
      OFS_FRAG_LO: frag_r[7:0] = b;
      OFS_TTL:     ttl_r = b;
      OFS_PROTO:   proto_r = b;
      OFS_SRC0, OFS_SRC1, OFS_SRC2, OFS_SRC3: src_r = {src_r[23:0], b};
      OFS_DST0, OFS_DST1, OFS_DST2, OFS_DST3: dst_r = {dst_r[23:0], b};
      default: ;
    endcase
    hlen = {ver_ihl_r[3:0], 2'b00};
    // even offsets hold the high byte, odd offsets add the word
    if (idx < {10'd0, hlen}) begin
      if (!idx[0]) hi_byte_r = b;
      else csum_acc_r = csum_acc_r + {6'd0, hi_byte_r, b};
    end
    if (last) begin
      fold = {1'b0, csum_acc_r[15:0]} + {11'd0, csum_acc_r[ACC_W-1:16]};
      fold = {1'b0, fold[15:0]} + {16'd0, fold[16]};
      res = '0;
      if (seen_bytes < MIN_PKT_LEN) res.verdict = VERDICT_SHORT;
      else if (ttl_r == 8'd0) res.verdict = VERDICT_TTL_ZERO;
      else if (ver_ihl_r[7:4] != IPV4_VERSION) res.verdict = VERDICT_BAD_VER;
      else if (seen_bytes < {10'd0, hlen} || seen_bytes < tot_len_r)
        res.verdict = VERDICT_BAD_LEN;
      else if (fold[15:0] != CSUM_GOOD) res.verdict = VERDICT_BAD_CSUM;
      else if ((frag_r & (MF_BIT | OFFSET_MASK)) != 16'd0) res.verdict = VERDICT_FRAGMENT;
      else res.verdict = VERDICT_ACCEPT;
      res.icmp  = (res.verdict == VERDICT_ACCEPT) && (proto_r == PROTO_ICMP);
      res.proto = proto_r;
      res.hlen  = hlen;
      res.plen  = (tot_len_r > {10'd0, hlen}) ? tot_len_r - {10'd0, hlen} : 16'd0;
      res.src   = src_r;
      res.dst   = dst_r;
      verdict_q.push_back(res);
      // next packet starts from a clean slate
      seen_bytes = '0;
      ver_ihl_r  = '0;
      ttl_r      = '0;
      tot_len_r  = '0;
      frag_r     = '0;
      proto_r    = '0;
      src_r      = '0;
      dst_r      = '0;
      csum_acc_r = '0;
      hi_byte_r  = '0;
    end
  endtask

  // build one datagram, optionally with a correct checksum, and queue nbytes of it
  function automatic int push_datagram(input logic [3:0] ver, input logic [3:0] ihl,
                                       input logic [15:0] tlen, input logic [15:0] frag,
                                       input logic [7:0] ttl, input logic [7:0] proto,
                                       input logic [31:0] src, input logic [31:0] dst,
                                       input bit fix, input int nbytes);
    logic [7:0]       pkt [];
    int               hlen;
    int               size;
    logic [ACC_W-1:0] acc;
    logic [16:0]      fold;
    byte_beat_t       bt;
    hlen = ihl * 4;
    size = nbytes;
    if (size < 20) size = 20;
    if (size < hlen) size = hlen;
    pkt = new[size];
    foreach (pkt[i]) pkt[i] = 8'($urandom);
    pkt[0] = {ver, ihl};
    {pkt[2], pkt[3]} = tlen;
    {pkt[6], pkt[7]} = frag;
    pkt[8] = ttl;
    pkt[9] = proto;
    {pkt[12], pkt[13], pkt[14], pkt[15]} = src;
    {pkt[16], pkt[17], pkt[18], pkt[19]} = dst;
    // checksum field only lies inside the summed range from 12 bytes up
    if (fix && hlen >= 12) begin
      pkt[10] = 8'd0;
      pkt[11] = 8'd0;
      acc = '0;
      for (int i = 0; i < hlen; i += 2) acc = acc + {6'd0, pkt[i], pkt[i+1]};
      fold = {1'b0, acc[15:0]} + {11'd0, acc[ACC_W-1:16]};
      fold = {1'b0, fold[15:0]} + {16'd0, fold[16]};
      {pkt[10], pkt[11]} = ~fold[15:0];
    end
    for (int i = 0; i < nbytes; i++) begin
      bt.data = pkt[i];
      bt.last = (i == nbytes - 1);
      rx_byte_q.push_back(bt);
    end
    return nbytes;
  endfunction

  // mostly well-formed datagrams, some with one fault, some pure noise
  function automatic int push_random_datagram();
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [15:0] tlen;
    logic [15:0] frag;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    bit          fix;
    int          nbytes;
    int          hlen;
    if ($urandom_range(99) < 20) begin
      ver    = 4'($urandom);
      ihl    = 4'($urandom);
      tlen   = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(80));
      frag   = 16'($urandom);
      ttl    = 8'($urandom);
      proto  = 8'($urandom);
      fix    = 1'($urandom_range(1));
      nbytes = $urandom_range(1, 70);
    end else begin
      ver    = IPV4_VERSION;
      ihl    = ($urandom_range(2) != 0) ? 4'd5 : 4'($urandom_range(5, 15));
      hlen   = ihl * 4;
      tlen   = 16'(hlen + $urandom_range(32));
      nbytes = tlen + (($urandom_range(9) == 0) ? $urandom_range(1, 4) : 0);
      frag   = $urandom_range(1) ? 16'h4000 : 16'h0000;
      ttl    = 8'($urandom_range(1, 255));
      proto  = $urandom_range(1) ? PROTO_ICMP : 8'($urandom);
      fix    = 1'b1;
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(7))
          0: ttl = 8'd0;
          1: ver = 4'($urandom_range(5, 19));
          2: frag = frag | MF_BIT;
          3: frag = frag | 16'($urandom_range(1, 16'h1fff));
          4: fix = 1'b0;
          5: nbytes = $urandom_range(1, tlen - 1);
          6: tlen = 16'($urandom_range(hlen - 1));
          default: ihl = 4'($urandom_range(4));
        endcase
      end
    end
    return push_datagram(ver, ihl, tlen, frag, ttl, proto, 32'($urandom), 32'($urandom),
                         fix, nbytes);
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (rx_byte_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
  endtask

  task automatic random_phase(input int unsigned sidle, input int unsigned rstall,
                              input int target);
    int count;
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    count = 0;
    while (count < target) count += push_random_datagram();
    wait_drained();
  endtask

  // byte driver: hold a beat until taken, predict on every accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tlast  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) header_check_step(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (rx_byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_beat = rx_byte_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_beat.data;
          s_tlast  <= next_beat.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // verdict receiver: random stalls plus a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready  <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // verdict monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      got_beat = m_tdata;
      if (verdict_q.size() == 0) begin
        $display("%0t: verdict beat with none expected, actual %h", $time, m_tdata);
        errors++;
      end else begin
        want_beat = verdict_q.pop_front();
        if (got_beat != want_beat) begin
          $display({"%0t: verdict beat mismatch\n",
                    "  expected verdict=%0d icmp=%0d proto=%0d hlen=%0d plen=%0d",
                    " src=%h dst=%h pad=%h\n",
                    "  actual   verdict=%0d icmp=%0d proto=%0d hlen=%0d plen=%0d",
                    " src=%h dst=%h pad=%h"}, $time,
                   want_beat.verdict, want_beat.icmp, want_beat.proto, want_beat.hlen,
                   want_beat.plen, want_beat.src, want_beat.dst, want_beat.pad,
                   got_beat.verdict, got_beat.icmp, got_beat.proto, got_beat.hlen,
                   got_beat.plen, got_beat.src, got_beat.dst, got_beat.pad);
          errors++;
        end
      end
    end
  end

  // stimulus and phase sequencing
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: accepted icmp, max ihl with options, address and protocol extremes
    void'(push_datagram(IPV4_VERSION, 4'd5, 16'd28, 16'h0000, 8'd64, PROTO_ICMP,
                        32'hc0a80001, 32'h0a000001, 1'b1, 28));
    void'(push_datagram(IPV4_VERSION, 4'd15, 16'd64, 16'h4000, 8'd255, 8'd6,
                        32'hffffffff, 32'h00000000, 1'b1, 64));
    void'(push_datagram(IPV4_VERSION, 4'd5, 16'd20, 16'h0000, 8'd1, 8'd255,
                        32'h00000000, 32'hffffffff, 1'b1, 20));
    // short packets, one byte and one below the minimum
    void'(push_datagram(IPV4_VERSION, 4'd5, 16'd20, 16'h0000, 8'd64, 8'd17,
                        32'h01020304, 32'h05060708, 1'b1, 1));
    void'(push_datagram(IPV4_VERSION, 4'd5, 16'd20, 16'h0000, 8'd64, 8'd17,
                        32'h01020304, 32'h05060708, 1'b1, 19));
    // ttl zero, wrong version
    void'(push_datagram(IPV4_VERSION, 4'd5, 16'd24, 16'h0000, 8'd0, PROTO_ICMP,
                        32'h11111111, 32'h22222222, 1'b1, 24));
    void'(push_datagram(4'd6, 4'd5, 16'd24, 16'h0000, 8'd9, PROTO_ICMP,
                        32'h33333333, 32'h44444444, 1'b1, 24));
    // bad length: packet shorter than total length, then shorter than header
    void'(push_datagram(IPV4_VERSION, 4'd5, 16'd40, 16'h0000, 8'd9, 8'd6,
                        32'h55555555, 32'h66666666, 1'b1, 30));
    void'(push_datagram(IPV4_VERSION, 4'd15, 16'd60, 16'h0000, 8'd9, 8'd6,
                        32'h77777777, 32'h88888888, 1'b1, 40));
    // bad checksum, more-fragments, nonzero offset
    void'(push_datagram(IPV4_VERSION, 4'd5, 16'd20, 16'h0000, 8'd9, 8'd6,
                        32'h99999999, 32'haaaaaaaa, 1'b0, 20));
    void'(push_datagram(IPV4_VERSION, 4'd5, 16'd20, MF_BIT, 8'd9, 8'd6,
                        32'hbbbbbbbb, 32'hcccccccc, 1'b1, 20));
    void'(push_datagram(IPV4_VERSION, 4'd5, 16'd20, OFFSET_MASK, 8'd9, 8'd6,
                        32'hdddddddd, 32'heeeeeeee, 1'b1, 20));
    // ihl zero: nothing summed, fails on checksum
    void'(push_datagram(IPV4_VERSION, 4'd0, 16'd20, 16'h0000, 8'd9, PROTO_ICMP,
                        32'h12345678, 32'h9abcdef0, 1'b1, 20));
    // total length below header length: payload clamps to zero
    void'(push_datagram(IPV4_VERSION, 4'd6, 16'd10, 16'h0000, 8'd9, PROTO_ICMP,
                        32'h0badf00d, 32'hfeedface, 1'b1, 24));
    random_phase(0, 0, 250);

    random_phase(49, 0, 300);
    random_phase(0, 49, 300);
    random_phase(27, 27, 300);

    // receiver holds off while short packets pile up behind it
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_seq       = hold_seq + 1;
    sent = 0;
    for (int i = 0; i < 30; i++) begin
      sent += push_datagram(4'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
                            8'($urandom), 8'($urandom), 32'($urandom), 32'($urandom),
                            1'b1, $urandom_range(1, 3));
    end
    while (sent < 100) sent += push_random_datagram();
    wait_drained();

    // let any stray beat show up before the final word
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
    if (errors == 0) begin
      $display("** ipv4_receive_header_checker_core: PASSED **");
    end else begin
      $display("** ipv4_receive_header_checker_core: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #15000000;
    $display("** ipv4_receive_header_checker_core: FAILED **");
    $finish;
  end

endmodule

// File: ipv4_receive_header_checker_core.f
+incdir+sv
sv/ihc_pkg.sv
sv/ihc_front.sv
sv/ihc_queue.sv
sv/ihc_back.sv
sv/ipv4_receive_header_checker_core.sv
tb/ipv4_receive_header_checker_core_tb.sv
